FILE: sv/on_delay_timer_bank_top_assert.svh
// Assertion macros shared by the timer bank RTL.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ON_DELAY_TIMER_BANK_TOP_ASSERT_SVH
`define ON_DELAY_TIMER_BANK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define OTDTB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define OTDTB_IMPLY(label, ante, cons, msg) \
	`OTDTB_ASSERT(label, (ante) |-> (cons), msg)

`else

`define OTDTB_ASSERT(label, prop, msg)
`define OTDTB_IMPLY(label, ante, cons, msg)

`endif

`endif

FILE: sv/otdtb_pkg.sv
`default_nettype none

package otdtb_pkg;

	// Width of the fields carried on the ports.
	localparam int unsigned OP_W    = 2;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned REPORT_W = 16;

	// Operation codes of an input transaction.
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_EVAL  = 2'd1,
		OP_WTHR  = 2'd2,
		OP_WEN   = 2'd3
	} op_t;

	// Command broadcast from the top level to every cell.
	typedef struct packed {
		logic               valid;
		op_t                op;
		logic               level;
		logic               rst_req;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	// Status that one cell reports back for the result.
	typedef struct packed {
		logic [REPORT_W-1:0] count;
		logic                busy;
		logic                finished;
		logic                enabled;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/otdtb_cell.sv
`default_nettype none

module otdtb_cell #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire otdtb_pkg::cmd_t   cmd,
	input  wire logic              hit,
	input  wire logic              reach_in,
	output logic                   reach_out,
	output logic                   tout,
	output otdtb_pkg::status_t     status
);
	import otdtb_pkg::*;

	`include "on_delay_timer_bank_top_assert.svh"

	logic                   enable_q;
	logic [COUNT_WIDTH-1:0] thr_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   busy_q;
	logic                   fin_q;
	logic                   hold_q;
	logic                   trig_q;

	logic                   active;
	logic                   do_tick;
	logic                   do_eval;
	logic [COUNT_WIDTH-1:0] cnt_inc;

	// The sweep passes on to the next cell only through an enabled cell.
	assign active    = reach_in & enable_q;
	assign reach_out = active;

	assign do_tick = cmd.valid && (cmd.op == OP_TICK) && active;
	assign do_eval = cmd.valid && (cmd.op == OP_EVAL) && hit;

	// Saturating increment of the tick count.
	assign cnt_inc = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

	// Delayed output of an evaluate, from the state before the update.
	assign tout = do_eval && cmd.level && !cmd.rst_req &&
		(fin_q || (thr_q == '0));

	// Timer state update for ticks, evaluates and writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			thr_q    <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			fin_q    <= 1'b0;
			hold_q   <= 1'b0;
			trig_q   <= 1'b0;
		end else if (do_tick) begin
			priority if (hold_q) begin
				cnt_q  <= '0;
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_inc;
				if (cnt_inc >= thr_q) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b1;
			end else if (trig_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (cmd.valid && hit) begin
			unique case (cmd.op)
				OP_EVAL: begin
					trig_q <= cmd.level;
					priority if (!cmd.level) begin
						cnt_q  <= '0;
						busy_q <= 1'b0;
						fin_q  <= 1'b0;
					end else if (cmd.rst_req) begin
						hold_q <= 1'b1;
					end else if (!fin_q) begin
						hold_q <= 1'b0;
					end
				end
				OP_WTHR: begin
					thr_q <= COUNT_WIDTH'({{COUNT_WIDTH{1'b0}}, cmd.value});
				end
				OP_WEN: begin
					enable_q <= cmd.value[0];
				end
				default: begin
					thr_q <= thr_q;
				end
			endcase
		end
	end

	// Status seen by the result stage; the count is reported in its low bits.
	assign status.count    = REPORT_W'({{REPORT_W{1'b0}}, cnt_q});
	assign status.busy     = busy_q;
	assign status.finished = fin_q;
	assign status.enabled  = enable_q;

	`OTDTB_IMPLY(a_busy_fin_excl, busy_q, !fin_q, "cell is busy and finished at once")
	`OTDTB_IMPLY(a_reach_needs_en, reach_out, reach_in && enable_q, "sweep passed a disabled cell")
	`OTDTB_IMPLY(a_tout_only_eval, tout, do_eval, "timer output outside an evaluate")

endmodule

`default_nettype wire

FILE: sv/on_delay_timer_bank_top.sv
`default_nettype none

// Bank of TIMER_COUNT on-delay timers, one per cell in a row of cells. Each
// input transaction is a tick, an evaluate, a threshold write or an enable
// write, and produces exactly one result transaction with the addressed
// timer's status after the operation (all zero for an index beyond the bank).
// A tick updates every timer that the sweep reaches, all in the same cycle;
// the sweep ripples from cell zero and stops at the first disabled cell. One
// transaction is taken per clock while the result side keeps up. The cells
// update at the accepting edge, and the addressed status is picked by a
// one-hot select into the output register when the select stage advances.
// Counts saturate at their largest COUNT_WIDTH-bit value.
module on_delay_timer_bank_top #(
	parameter int unsigned TIMER_COUNT = 16,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [otdtb_pkg::OP_W-1:0]       operation,
	input  wire logic [otdtb_pkg::INDEX_W-1:0]    timer_index,
	input  wire logic                             input_level,
	input  wire logic                             reset_request,
	input  wire logic [otdtb_pkg::VALUE_W-1:0]    write_value,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic                                  timer_out,
	output logic [otdtb_pkg::REPORT_W-1:0]        count,
	output logic                                  busy_res,
	output logic                                  finished,
	output logic                                  enabled
);
	import otdtb_pkg::*;

	`include "on_delay_timer_bank_top_assert.svh"

	logic                   accept;
	logic                   s1_adv;
	logic                   s1_valid_q;
	logic [TIMER_COUNT-1:0] sel_s1;
	logic                   tout_s1;
	op_t                    op_s1;
	logic                   result_valid_q;
	status_t                result_q;
	logic                   tout_q;

	cmd_t                   cmd;
	logic [TIMER_COUNT-1:0] hit;
	logic [TIMER_COUNT:0]   reach;
	logic [TIMER_COUNT-1:0] tout_cell;
	status_t                stat [TIMER_COUNT];
	status_t                rd_status;
	logic                   tout_any;

	// Handshake: the select stage moves on when the output register is free.
	assign s1_adv     = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !s1_adv;
	assign accept     = item_valid && !item_stall;

	// Command broadcast to the cells.
	assign cmd.valid   = accept;
	assign cmd.op      = op_t'(operation);
	assign cmd.level   = input_level;
	assign cmd.rst_req = reset_request;
	assign cmd.value   = write_value;

	// Sweep enters the row at cell zero.
	assign reach[0] = 1'b1;

	// Row of timer cells.
	for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
		assign hit[i] = (32'(timer_index) == i);

		otdtb_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.hit      (hit[i]),
			.reach_in (reach[i]),
			.reach_out(reach[i+1]),
			.tout     (tout_cell[i]),
			.status   (stat[i])
		);
	end

	assign tout_any = |tout_cell;

	// Select stage: remembers which cell the result reports on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1  <= hit;
			tout_s1 <= tout_any;
			op_s1   <= cmd.op;
		end
	end

	// One-hot read of the addressed cell's status after the update.
	always_comb begin
		rd_status = '0;
		for (int i = 0; i < TIMER_COUNT; i++) begin
			if (sel_s1[i]) begin
				rd_status = status_t'(rd_status | stat[i]);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_q <= rd_status;
			tout_q   <= tout_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign timer_out    = tout_q;
	assign count        = result_q.count;
	assign busy_res     = result_q.busy;
	assign finished     = result_q.finished;
	assign enabled      = result_q.enabled;

	`OTDTB_IMPLY(a_stall_when_full, item_stall, s1_valid_q && result_valid_q && result_stall, "input stalled without a full pipeline")
	`OTDTB_IMPLY(a_tout_eval_only, s1_valid_q && (op_s1 != OP_EVAL), !tout_s1, "timer output set for a non-evaluate transaction")
	`OTDTB_ASSERT(a_sel_onehot0, !s1_valid_q || $onehot0(sel_s1), "result select addresses more than one timer")
	`OTDTB_IMPLY(a_result_loaded, $past(s1_adv), result_valid_q, "select stage advanced but no result appeared")

endmodule

`default_nettype wire

FILE: tb/on_delay_timer_bank_top_test.sv
`timescale 1ns / 1ps

module on_delay_timer_bank_top_test;
	import otdtb_pkg::*;

	localparam int unsigned TIMERS = 16;
	localparam int unsigned CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int unsigned RANDOM_ITEMS = 1050;

	// Status of the addressed timer as carried by one result transaction.
	typedef struct packed {
		logic                timer_out;
		logic [REPORT_W-1:0] count;
		logic                busy;
		logic                finished;
		logic                enabled;
	} timer_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [OP_W-1:0]     operation = '0;
	logic [INDEX_W-1:0]  timer_index = '0;
	logic                input_level = 1'b0;
	logic                reset_request = 1'b0;
	logic [VALUE_W-1:0]  write_value = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic                timer_out;
	logic [REPORT_W-1:0] count;
	logic                busy_res;
	logic                finished;
	logic                enabled;

	// Shadow copy of the timer bank, advanced once per accepted transaction.
	bit             timer_enable [TIMERS];
	bit [CNT_W-1:0] timer_threshold [TIMERS];
	bit [CNT_W-1:0] timer_ticks [TIMERS];
	bit             timer_busy [TIMERS];
	bit             timer_done [TIMERS];
	bit             timer_hold [TIMERS];
	bit             timer_trigger [TIMERS];

	timer_report_t expected_reports[$];
	int unsigned   items_accepted = 0;
	int unsigned   mismatch_count = 0;
	logic          steady = 1'b0;

	on_delay_timer_bank_top #(
		.TIMER_COUNT(TIMERS),
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.timer_index(timer_index),
		.input_level(input_level),
		.reset_request(reset_request),
		.write_value(write_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.timer_out(timer_out),
		.count(count),
		.busy_res(busy_res),
		.finished(finished),
		.enabled(enabled)
	);

	always #5 clk = ~clk;

	// Applies one operation to the shadow bank and returns the status it reports.
	function automatic timer_report_t apply_to_bank(op_t op, logic [INDEX_W-1:0] idx,
			logic lvl, logic rst, logic [VALUE_W-1:0] value);
		timer_report_t rep;
		logic          out_bit;
		int unsigned   t;
		rep = '0;
		out_bit = 1'b0;
		t = 32'(idx);
		if (op == OP_TICK) begin
			// The sweep runs in index order up to the first disabled timer.
			for (int k = 0; k < TIMERS; k++) begin
				if (!timer_enable[k])
					break;
				if (timer_hold[k]) begin
					timer_ticks[k] = '0;
					timer_busy[k] = 1'b0;
					timer_done[k] = 1'b0;
				end else if (timer_busy[k]) begin
					if (timer_ticks[k] != CNT_MAX)
						timer_ticks[k]++;
					if (timer_ticks[k] >= timer_threshold[k]) begin
						timer_busy[k] = 1'b0;
						timer_done[k] = 1'b1;
					end
				end else if (!timer_done[k] && timer_trigger[k]) begin
					timer_busy[k] = 1'b1;
					timer_ticks[k] = '0;
				end
			end
		end else if (t < TIMERS) begin
			case (op)
				OP_EVAL: begin
					timer_trigger[t] = lvl;
					if (!lvl) begin
						timer_ticks[t] = '0;
						timer_busy[t] = 1'b0;
						timer_done[t] = 1'b0;
					end else if (rst) begin
						timer_hold[t] = 1'b1;
					end else if (timer_done[t]) begin
						out_bit = 1'b1;
					end else begin
						timer_hold[t] = 1'b0;
						out_bit = (timer_threshold[t] == '0);
					end
				end
				OP_WTHR: timer_threshold[t] = value[CNT_W-1:0];
				OP_WEN: timer_enable[t] = value[0];
				default: ;
			endcase
		end
		// An index beyond the bank reports zero in every field.
		if (t < TIMERS) begin
			rep.timer_out = out_bit;
			rep.count = timer_ticks[t][REPORT_W-1:0];
			rep.busy = timer_busy[t];
			rep.finished = timer_done[t];
			rep.enabled = timer_enable[t];
		end
		return rep;
	endfunction

	// Offers one transaction, holds it through stalls and records its expected result.
	task automatic send_item(input op_t op, input logic [INDEX_W-1:0] idx, input logic lvl,
			input logic rst, input logic [VALUE_W-1:0] value);
		if (!steady && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		item_valid <= 1'b1;
		operation <= op;
		timer_index <= idx;
		input_level <= lvl;
		reset_request <= rst;
		write_value <= value;
		do @(posedge clk); while (item_stall);
		expected_reports.push_back(apply_to_bank(op, idx, lvl, rst, value));
		items_accepted++;
	endtask

	// The fields that an operation ignores carry random values.
	task automatic tick_bank();
		send_item(OP_TICK, INDEX_W'($urandom_range(15)), 1'($urandom_range(1)),
			1'($urandom_range(1)), VALUE_W'($urandom_range(16'hFFFF)));
	endtask

	task automatic evaluate_timer(input logic [INDEX_W-1:0] idx, input logic lvl,
			input logic rst);
		send_item(OP_EVAL, idx, lvl, rst, VALUE_W'($urandom_range(16'hFFFF)));
	endtask

	task automatic write_threshold(input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] value);
		send_item(OP_WTHR, idx, 1'($urandom_range(1)), 1'($urandom_range(1)), value);
	endtask

	task automatic write_enable(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value);
		send_item(OP_WEN, idx, 1'($urandom_range(1)), 1'($urandom_range(1)), value);
	endtask

	// Out of reset every threshold is zero, so a high level gives an output at once.
	task automatic test_reset_state();
		evaluate_timer(15, 1'b1, 1'b0);
		tick_bank();
		write_enable(15, 16'hFFFE);
		evaluate_timer(15, 1'b0, 1'b0);
	endtask

	// A triggered timer starts on one tick and finishes when it reaches its threshold.
	task automatic test_on_delay();
		write_enable(0, 16'h0001);
		write_threshold(0, 16'd3);
		evaluate_timer(0, 1'b1, 1'b0);
		repeat (4) tick_bank();
		evaluate_timer(0, 1'b1, 1'b0);
		evaluate_timer(0, 1'b0, 1'b0);
	endtask

	// A reset request holds the timer cleared until an evaluate without it.
	task automatic test_hold_reset();
		evaluate_timer(0, 1'b1, 1'b1);
		tick_bank();
		evaluate_timer(0, 1'b1, 1'b0);
		tick_bank();
		tick_bank();
	endtask

	// A disabled timer stops the sweep, so the timers above it do not move.
	task automatic test_sweep_stop();
		write_enable(1, 16'h0000);
		write_enable(2, 16'hFFFF);
		evaluate_timer(2, 1'b1, 1'b0);
		tick_bank();
		write_enable(1, 16'h0001);
		tick_bank();
	endtask

	// With every timer enabled the sweep reaches the last one.
	task automatic test_all_enabled();
		for (int k = 1; k < TIMERS; k++)
			write_enable(INDEX_W'(k), 16'h0001);
		evaluate_timer(15, 1'b1, 1'b0);
		write_threshold(15, 16'd1);
		tick_bank();
		tick_bank();
		evaluate_timer(15, 1'b1, 1'b0);
	endtask

	// A full-scale threshold keeps the timer counting through a long run of ticks.
	task automatic test_full_threshold();
		steady <= 1'b1;
		write_threshold(0, 16'hFFFF);
		evaluate_timer(0, 1'b0, 1'b0);
		evaluate_timer(0, 1'b1, 1'b0);
		repeat (200) tick_bank();
		evaluate_timer(0, 1'b1, 1'b0);
	endtask

	// Random episodes: mostly a timer armed and ticked past its threshold, plus noise.
	task automatic test_random();
		int unsigned t;
		int unsigned pick;
		while (items_accepted < RANDOM_ITEMS) begin
			steady <= (items_accepted % 1000) >= 400 && (items_accepted % 1000) < 600;
			t = $urandom_range(TIMERS - 1);
			pick = $urandom_range(99);
			if (pick < 60) begin
				// Enable the prefix so the sweep reaches the chosen timer.
				for (int k = 0; k <= t; k++)
					if (!timer_enable[k])
						write_enable(INDEX_W'(k),
							VALUE_W'($urandom_range(16'hFFFF) | 16'h0001));
				if ($urandom_range(3) != 0)
					write_threshold(INDEX_W'(t), ($urandom_range(3) == 0) ?
						VALUE_W'($urandom_range(16'hFFFF)) :
						VALUE_W'($urandom_range(6)));
				evaluate_timer(INDEX_W'(t), 1'b1, $urandom_range(6) == 0);
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(3) == 0)
						evaluate_timer(INDEX_W'($urandom_range(15)),
							$urandom_range(3) != 0, $urandom_range(9) == 0);
					else
						tick_bank();
				end
				evaluate_timer(INDEX_W'(t), $urandom_range(3) != 0,
					$urandom_range(9) == 0);
			end else if (pick < 85) begin
				send_item(op_t'($urandom_range(3)), INDEX_W'($urandom_range(15)),
					1'($urandom_range(1)), 1'($urandom_range(1)),
					VALUE_W'($urandom_range(16'hFFFF)));
			end else begin
				write_enable(INDEX_W'(t), VALUE_W'($urandom_range(16'hFFFF) & 16'hFFFE));
			end
		end
	endtask

	// The receiver stalls at random except during the steady stretches.
	always @(posedge clk)
		result_stall <= !steady && ($urandom_range(99) < 38);

	// Reports one field that differs from its expectation.
	task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		mismatch_count++;
	endtask

	// Each accepted result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		timer_report_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: result transaction with no expectation, count %0h", $time, count);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (timer_out !== want.timer_out)
					flag_field("timer_out", 32'(want.timer_out), 32'(timer_out));
				if (count !== want.count)
					flag_field("count", 32'(want.count), 32'(count));
				if (busy_res !== want.busy)
					flag_field("busy_res", 32'(want.busy), 32'(busy_res));
				if (finished !== want.finished)
					flag_field("finished", 32'(want.finished), 32'(finished));
				if (enabled !== want.enabled)
					flag_field("enabled", 32'(want.enabled), 32'(enabled));
			end
		end
	end

	// Main sequence: reset, directed tests, random traffic, then drain.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_on_delay();
		test_hold_reset();
		test_sweep_stop();
		test_all_enabled();
		test_full_threshold();
		test_random();
		item_valid <= 1'b0;
		steady <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Run limit, well beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/otdtb_pkg.sv
sv/otdtb_cell.sv
sv/on_delay_timer_bank_top.sv
tb/on_delay_timer_bank_top_test.sv
